[hw/rtl/bcb_pkg.sv]
// Package for the bracelet counter: widths, microcode opcodes, jump conditions,
// step labels and the microcode ROM.
// No dependencies.
package bcb_pkg;

    localparam int COLOR_W         = 6;
    localparam int BEAD_W          = 6;
    localparam int COUNT_W         = 17;
    localparam int ACC_W           = 24;
    localparam int PROD_W          = COLOR_W + BEAD_W;
    localparam int REM_W           = BEAD_W + 1;
    localparam int PC_W            = 4;
    localparam int DIV_STEPS       = ACC_W;
    localparam int MAX_PRODUCT_DEF = 32;

    typedef enum logic [3:0] {
        OP_INIT,
        OP_GCD_LD,
        OP_GCD_SUB,
        OP_POW_LD,
        OP_POW_MUL,
        OP_ACC_POW,
        OP_REF_LD,
        OP_REF_ADJ,
        OP_REF_ACC,
        OP_DIV_LD,
        OP_DIV_STEP,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_SKIP,
        COND_G_NE,
        COND_E_NZ,
        COND_I_NE_S
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    localparam logic [PC_W-1:0] ST_INIT     = 4'd0;
    localparam logic [PC_W-1:0] ST_GCD_LD   = 4'd1;
    localparam logic [PC_W-1:0] ST_GCD_SUB  = 4'd2;
    localparam logic [PC_W-1:0] ST_POW_LD   = 4'd3;
    localparam logic [PC_W-1:0] ST_POW_MUL  = 4'd4;
    localparam logic [PC_W-1:0] ST_ACC_POW  = 4'd5;
    localparam logic [PC_W-1:0] ST_REF_LD   = 4'd6;
    localparam logic [PC_W-1:0] ST_REF_POW  = 4'd7;
    localparam logic [PC_W-1:0] ST_REF_ADJ  = 4'd8;
    localparam logic [PC_W-1:0] ST_REF_ACC  = 4'd9;
    localparam logic [PC_W-1:0] ST_DIV_LD   = 4'd10;
    localparam logic [PC_W-1:0] ST_DIV_STEP = 4'd11;
    localparam logic [PC_W-1:0] ST_EMIT     = 4'd12;

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            ST_INIT:     w = '{OP_INIT,     COND_SKIP,   ST_EMIT};
            ST_GCD_LD:   w = '{OP_GCD_LD,   COND_NEVER,  ST_INIT};
            ST_GCD_SUB:  w = '{OP_GCD_SUB,  COND_G_NE,   ST_GCD_SUB};
            ST_POW_LD:   w = '{OP_POW_LD,   COND_NEVER,  ST_INIT};
            ST_POW_MUL:  w = '{OP_POW_MUL,  COND_E_NZ,   ST_POW_MUL};
            ST_ACC_POW:  w = '{OP_ACC_POW,  COND_I_NE_S, ST_GCD_LD};
            ST_REF_LD:   w = '{OP_REF_LD,   COND_NEVER,  ST_INIT};
            ST_REF_POW:  w = '{OP_POW_MUL,  COND_E_NZ,   ST_REF_POW};
            ST_REF_ADJ:  w = '{OP_REF_ADJ,  COND_NEVER,  ST_INIT};
            ST_REF_ACC:  w = '{OP_REF_ACC,  COND_NEVER,  ST_INIT};
            ST_DIV_LD:   w = '{OP_DIV_LD,   COND_NEVER,  ST_INIT};
            ST_DIV_STEP: w = '{OP_DIV_STEP, COND_E_NZ,   ST_DIV_STEP};
            ST_EMIT:     w = '{OP_EMIT,     COND_NEVER,  ST_INIT};
            default:     w = '{OP_EMIT,     COND_NEVER,  ST_INIT};
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/bracelet_count_burnside.sv]
// Bracelet counter (Burnside over the dihedral group): microcoded sequencer
// and its datapath. Depends on bcb_pkg.
//
// Usage: present colors and beads on s_colors/s_beads with s_valid; the
// transaction is taken when s_valid and s_ready are both high. s_ready is high
// whenever no item is in work, even while a finished result waits on m_*.
// One result transaction per input on m_count/m_out_of_range with m_valid and
// m_ready. When colors*beads exceeds MAX_PRODUCT, m_out_of_range is 1 and
// m_count is 0. Otherwise the run time is set by the subtractive gcd loop and
// the one-multiply-per-cycle power loop; the divide by 2*beads is a load, 24
// quotient bits at one per cycle, and an exit step.
// Throughput: one item at a time; the next is taken once the result is loaded
// into the output register.
// Reset (aresetn low, synchronous) drops any item in work and any waiting
// result. If the receiver stalls, the sequencer holds on its last step until
// the output register frees, and s_ready stays low until then.
module bracelet_count_burnside
    import bcb_pkg::*;
#(
    parameter int MAX_PRODUCT = MAX_PRODUCT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COLOR_W-1:0] s_colors,
    input  logic [BEAD_W-1:0]  s_beads,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COUNT_W-1:0] m_count,
    output logic               m_out_of_range
);

    localparam logic [PROD_W-1:0] MaxProd = PROD_W'(MAX_PRODUCT);

    logic               busy_reg,    busy_next;
    logic [PC_W-1:0]    pc_reg,      pc_next;
    logic [COLOR_W-1:0] c_reg,       c_next;
    logic [BEAD_W-1:0]  s_reg,       s_next;
    logic [BEAD_W-1:0]  i_reg,       i_next;
    logic [BEAD_W-1:0]  ga_reg,      ga_next;
    logic [BEAD_W-1:0]  gb_reg,      gb_next;
    logic [BEAD_W-1:0]  e_reg,       e_next;
    logic [ACC_W-1:0]   p_reg,       p_next;
    logic [ACC_W-1:0]   sum_reg,     sum_next;
    logic [REM_W-1:0]   rem_reg,     rem_next;
    logic               flag_reg,    flag_next;
    logic               m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    logic               m_oor_reg,   m_oor_next;

    uword_t                     uw;
    logic [PROD_W-1:0]          prod;
    logic                       too_big;
    logic                       jump;
    logic                       stall;
    logic [ACC_W+COLOR_W-1:0]   pc_prod;
    logic [BEAD_W-1:0]          ref_factor;
    logic [ACC_W+BEAD_W-1:0]    ref_prod;
    logic [REM_W-1:0]           divisor;
    logic [REM_W:0]             trial;
    logic [REM_W:0]             diff;
    logic                       trial_ge;

    assign uw         = ucode(pc_reg);
    assign prod       = c_reg * s_reg;
    assign too_big    = prod > MaxProd;
    assign stall      = (uw.op == OP_EMIT) && m_valid_reg && !m_ready;
    assign pc_prod    = p_reg * c_reg;
    assign ref_factor = s_reg[0] ? s_reg : {1'b0, s_reg[BEAD_W-1:1]};
    assign ref_prod   = p_reg * ref_factor;
    assign divisor    = {s_reg, 1'b0};
    assign trial      = {rem_reg, sum_reg[ACC_W-1]};
    assign trial_ge   = trial >= {1'b0, divisor};
    assign diff       = trial - {1'b0, divisor};

    always_comb begin
        case (uw.cond)
            COND_NEVER:  jump = 1'b0;
            COND_SKIP:   jump = too_big || (s_reg == '0);
            COND_G_NE:   jump = ga_reg != gb_reg;
            COND_E_NZ:   jump = e_reg != '0;
            COND_I_NE_S: jump = i_reg != s_reg;
            default:     jump = 1'b0;
        endcase
    end

    always_comb begin
        busy_next    = busy_reg;
        pc_next      = pc_reg;
        c_next       = c_reg;
        s_next       = s_reg;
        i_next       = i_reg;
        ga_next      = ga_reg;
        gb_next      = gb_reg;
        e_next       = e_reg;
        p_next       = p_reg;
        sum_next     = sum_reg;
        rem_next     = rem_reg;
        flag_next    = flag_reg;
        m_valid_next = m_valid_reg;
        m_count_next = m_count_reg;
        m_oor_next   = m_oor_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (!busy_reg) begin
            if (s_valid) begin
                c_next    = s_colors;
                s_next    = s_beads;
                busy_next = 1'b1;
                pc_next   = ST_INIT;
            end
        end else if (!stall) begin
            pc_next = jump ? uw.target : pc_reg + 1'b1;
            case (uw.op)
                OP_INIT: begin
                    flag_next = too_big;
                    sum_next  = '0;
                    i_next    = BEAD_W'(1);
                end
                OP_GCD_LD: begin
                    ga_next = s_reg;
                    gb_next = i_reg;
                end
                OP_GCD_SUB: begin
                    if (ga_reg > gb_reg) begin
                        ga_next = ga_reg - gb_reg;
                    end else if (gb_reg > ga_reg) begin
                        gb_next = gb_reg - ga_reg;
                    end
                end
                OP_POW_LD: begin
                    e_next = ga_reg;
                    p_next = ACC_W'(1);
                end
                OP_POW_MUL: begin
                    if (e_reg != '0) begin
                        p_next = pc_prod[ACC_W-1:0];
                        e_next = e_reg - 1'b1;
                    end
                end
                OP_ACC_POW: begin
                    sum_next = sum_reg + p_reg;
                    i_next   = i_reg + 1'b1;
                end
                OP_REF_LD: begin
                    e_next = {1'b0, s_reg[BEAD_W-1:1]} + BEAD_W'(s_reg[0]);
                    p_next = ACC_W'(1);
                end
                OP_REF_ADJ: begin
                    if (!s_reg[0]) begin
                        p_next = pc_prod[ACC_W-1:0] + p_reg;
                    end
                end
                OP_REF_ACC: begin
                    sum_next = sum_reg + ref_prod[ACC_W-1:0];
                end
                OP_DIV_LD: begin
                    e_next   = BEAD_W'(DIV_STEPS);
                    rem_next = '0;
                end
                OP_DIV_STEP: begin
                    if (e_reg != '0) begin
                        rem_next = trial_ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
                        sum_next = {sum_reg[ACC_W-2:0], trial_ge};
                        e_next   = e_reg - 1'b1;
                    end
                end
                OP_EMIT: begin
                    m_valid_next = 1'b1;
                    m_count_next = sum_reg[COUNT_W-1:0];
                    m_oor_next   = flag_reg;
                    busy_next    = 1'b0;
                    pc_next      = ST_INIT;
                end
                default: begin
                    busy_next = 1'b0;
                    pc_next   = ST_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        c_reg       <= c_next;
        s_reg       <= s_next;
        i_reg       <= i_next;
        ga_reg      <= ga_next;
        gb_reg      <= gb_next;
        e_reg       <= e_next;
        p_reg       <= p_next;
        sum_reg     <= sum_next;
        rem_reg     <= rem_next;
        flag_reg    <= flag_next;
        m_count_reg <= m_count_next;
        m_oor_reg   <= m_oor_next;
    end

    assign s_ready        = !busy_reg;
    assign m_valid        = m_valid_reg;
    assign m_count        = m_count_reg;
    assign m_out_of_range = m_oor_reg;

    a_idle_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> pc_reg == ST_INIT)
        else $error("sequencer left its first step while idle");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> busy_reg && pc_reg == ST_INIT)
        else $error("accepted transaction did not start the program");

    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_oor_reg |-> m_count_reg == '0)
        else $error("flagged result carries a nonzero count");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && uw.op == OP_DIV_STEP |-> rem_reg < divisor)
        else $error("division remainder reached the divisor");

    a_emit_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && stall |=> busy_reg && pc_reg == ST_EMIT)
        else $error("sequencer moved past its last step while the output was full");

endmodule

[tb/sv/bracelet_check.sv]
// Checker for the bracelet counter: watches both handshake channels, predicts
// the bracelet count of every accepted query and compares it with the result.
// Depends on bcb_pkg.
module bracelet_check
    import bcb_pkg::*;
#(
    parameter int MAX_PRODUCT = MAX_PRODUCT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [COLOR_W-1:0] s_colors,
    input  logic [BEAD_W-1:0]  s_beads,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [COUNT_W-1:0] m_count,
    input  logic               m_out_of_range,
    input  logic               end_of_test,
    output int                 mismatch_count,
    output int                 outstanding,
    output int                 results_seen,
    output int                 flagged_seen
);

    typedef struct packed {
        logic [COLOR_W-1:0] colors;
        logic [BEAD_W-1:0]  beads;
        logic [COUNT_W-1:0] count;
        logic               out_of_range;
    } bracelet_query_t;

    bracelet_query_t expected_counts[$];
    bracelet_query_t oldest;

    initial begin
        mismatch_count = 0;
        outstanding    = 0;
        results_seen   = 0;
        flagged_seen   = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic longint unsigned color_power(input longint unsigned base,
                                                    input int unsigned exponent);
        longint unsigned acc;
        acc = 1;
        for (int unsigned k = 0; k < exponent; k++) begin
            acc = acc * base;
        end
        return acc;
    endfunction

    function automatic bracelet_query_t predict_bracelet_count(
        input logic [COLOR_W-1:0] colors,
        input logic [BEAD_W-1:0]  beads
    );
        bracelet_query_t q;
        longint unsigned total;
        int unsigned     c, s, a, g, t;
        q.colors       = colors;
        q.beads        = beads;
        q.count        = '0;
        q.out_of_range = 1'b0;
        c              = colors;
        s              = beads;
        total          = 0;
        if (c * s > MAX_PRODUCT) begin
            q.out_of_range = 1'b1;
        end else if (s != 0) begin
            // rotations: one term per shift, each a power of the cycle count
            for (int unsigned i = 1; i <= s; i++) begin
                a = s;
                g = i;
                while (g != 0) begin
                    t = a % g;
                    a = g;
                    g = t;
                end
                total += color_power(c, a);
            end
            // reflections
            if (s % 2 == 1) begin
                total += s * color_power(c, (s + 1) / 2);
            end else begin
                total += (s / 2) * (color_power(c, s / 2 + 1) + color_power(c, s / 2));
            end
            q.count = COUNT_W'(total / (2 * s));
        end
        return q;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_counts.size() == 0) begin
                    report_mismatch($sformatf("result count=%0d out_of_range=%0b with none pending",
                                              m_count, m_out_of_range));
                end else begin
                    oldest = expected_counts.pop_front();
                    if (oldest.out_of_range) flagged_seen++;
                    if (m_count !== oldest.count)
                        report_mismatch($sformatf("count colors=%0d beads=%0d: got %0d want %0d",
                                                  oldest.colors, oldest.beads,
                                                  m_count, oldest.count));
                    if (m_out_of_range !== oldest.out_of_range)
                        report_mismatch($sformatf("flag colors=%0d beads=%0d: got %0b want %0b",
                                                  oldest.colors, oldest.beads,
                                                  m_out_of_range, oldest.out_of_range));
                end
            end
            if (s_valid && s_ready)
                expected_counts.push_back(predict_bracelet_count(s_colors, s_beads));
            outstanding = expected_counts.size();
        end
    end

    always @(posedge end_of_test) begin
        if (expected_counts.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_counts.size()));
    end

endmodule

[tb/sv/tb.sv]
// Top of the bracelet counter testbench: clock, reset, query stimulus, output
// pacing and verdict. Depends on bcb_pkg, bracelet_count_burnside and bracelet_check.
module tb;
    import bcb_pkg::*;

    localparam int HOLD_CYCLES = 2000;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [COLOR_W-1:0] s_colors;
    logic [BEAD_W-1:0]  s_beads;
    logic               m_valid;
    logic               m_ready;
    logic [COUNT_W-1:0] m_count;
    logic               m_out_of_range;
    logic               hold_req;
    logic               hold_done;
    logic               end_of_test;

    int send_idle_pct = 31;
    int recv_idle_pct = 85;
    int mismatch_count;
    int outstanding;
    int results_seen;
    int flagged_seen;

    logic [11:0] corner_queries [0:21] = '{
        {6'd1, 6'd1},   {6'd32, 6'd1},  {6'd1, 6'd32},  {6'd2, 6'd16},
        {6'd16, 6'd2},  {6'd2, 6'd15},  {6'd3, 6'd10},  {6'd4, 6'd8},
        {6'd8, 6'd4},   {6'd5, 6'd6},   {6'd6, 6'd5},   {6'd3, 6'd3},
        {6'd2, 6'd2},   {6'd0, 6'd0},   {6'd0, 6'd7},   {6'd7, 6'd0},
        {6'd63, 6'd0},  {6'd0, 6'd63},  {6'd33, 6'd1},  {6'd1, 6'd33},
        {6'd6, 6'd6},   {6'd63, 6'd63}
    };

    always #5 aclk = ~aclk;

    bracelet_count_burnside uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_colors       (s_colors),
        .s_beads        (s_beads),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_count        (m_count),
        .m_out_of_range (m_out_of_range)
    );

    bracelet_check checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_colors       (s_colors),
        .s_beads        (s_beads),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_count        (m_count),
        .m_out_of_range (m_out_of_range),
        .end_of_test    (end_of_test),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .results_seen   (results_seen),
        .flagged_seen   (flagged_seen)
    );

    task automatic send_query(input logic [COLOR_W-1:0] c, input logic [BEAD_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_colors <= c;
        s_beads  <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic random_queries(input int n);
        int c;
        int b;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 70) begin
                b = ($urandom_range(99) < 80) ? $urandom_range(12, 1) : $urandom_range(32, 13);
                c = $urandom_range(32 / b, 1);
            end else begin
                c = $urandom_range(63, 0);
                b = $urandom_range(63, 0);
            end
            send_query(c[COLOR_W-1:0], b[BEAD_W-1:0]);
        end
    endtask

    // output side pacing; hold off for a long stretch once on request
    initial begin
        m_ready   = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready  <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_colors    = '0;
        s_beads     = '0;
        hold_req    = 1'b0;
        end_of_test = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (corner_queries[k])
            send_query(corner_queries[k][11:6], corner_queries[k][5:0]);
        random_queries(90);

        send_idle_pct = 85;
        recv_idle_pct = 31;
        random_queries(90);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req <= 1'b1;
        random_queries(90);
        s_valid <= 1'b0;

        while (outstanding != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        end_of_test = 1'b1;
        @(negedge aclk);

        $display("Checked %0d bracelet counts, %0d of them over the product limit,",
                 results_seen, flagged_seen);
        $display("across corner sizes, three pacing mixes and a %0d-cycle output stall.",
                 HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/bcb_pkg.sv
hw/rtl/bracelet_count_burnside.sv
tb/sv/bracelet_check.sv
tb/sv/tb.sv
